FILE: design/rmr_pkg.sv
// rmr_pkg: shared widths and defaults for the rational multiply-reduce block.
// No dependencies.
`default_nettype none

package rmr_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int FIELD_W           = 32;
  localparam int RESULT_W          = 64;

endpackage

`default_nettype wire

FILE: design/rational_multiply_reduce.sv
// Sequence: a request is taken in idle; the numerator and then the denominator product are formed
// (S_MULN, S_MULD). If either product is zero it goes straight to S_DONE; otherwise a binary
// gcd (S_GCD) and two restoring divisions by it (S_DIVN, S_DIVD) reduce the fraction first.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// The gcd and the divisions share one subtract/compare unit; the products share one multiplier.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the output register.
// Depends on rmr_pkg.
`default_nettype none

module rational_multiply_reduce #(
  parameter int OPERAND_WIDTH = rmr_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [rmr_pkg::FIELD_W-1:0] in_a_numerator,
  input  wire logic signed [rmr_pkg::FIELD_W-1:0] in_a_denominator,
  input  wire logic signed [rmr_pkg::FIELD_W-1:0] in_b_numerator,
  input  wire logic signed [rmr_pkg::FIELD_W-1:0] in_b_denominator,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [rmr_pkg::RESULT_W-1:0]     out_product_numerator,
  output logic signed [rmr_pkg::RESULT_W-1:0]     out_product_denominator
);

  localparam int OW    = OPERAND_WIDTH;
  localparam int PW    = 2 * OPERAND_WIDTH;
  localparam int RW    = rmr_pkg::RESULT_W;
  localparam int CNT_W = $clog2(PW);
  localparam int K_W   = $clog2(PW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULN = 3'd1;
  localparam logic [2:0] S_MULD = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIVN = 3'd4;
  localparam logic [2:0] S_DIVD = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PW - 1);

  function automatic logic [OW-1:0] mag_of(input logic [OW-1:0] v);
    mag_of = v[OW-1] ? (~v + OW'(1)) : v;
  endfunction

  function automatic logic [RW-1:0] to_bits(input logic neg, input logic [PW-1:0] mag);
    logic [RW-1:0] r;
    r = RW'(mag);
    to_bits = neg ? (RW'(0) - r) : r;
  endfunction

  logic [2:0]       state_r, state_nxt;
  logic [OW-1:0]    an_r, an_nxt, bn_r, bn_nxt, ad_r, ad_nxt, bd_r, bd_nxt;
  logic             num_neg_r, num_neg_nxt, den_neg_r, den_neg_nxt;
  logic [PW-1:0]    num_r, num_nxt, den_r, den_nxt;
  logic [PW-1:0]    x_r, x_nxt, y_r, y_nxt, g_r, g_nxt;
  logic [PW-1:0]    rem_r, rem_nxt, quo_r, quo_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [RW-1:0]    out_num_r, out_num_nxt, out_den_r, out_den_nxt;

  logic [OW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p;
  logic [PW-1:0] sub_a, sub_b;
  logic [PW:0]   sub_d;
  logic          borrow;
  logic          x_ge_y;
  logic [PW-1:0] rem_sh;
  logic [PW-1:0] quo_step;
  logic          accept;

  assign in_stall                = (state_r != S_IDLE);
  assign accept                  = in_valid && !in_stall;
  assign out_valid               = out_valid_r;
  assign out_product_numerator   = out_num_r;
  assign out_product_denominator = out_den_r;

  // shared multiplier
  assign mul_a = (state_r == S_MULN) ? an_r : ad_r;
  assign mul_b = (state_r == S_MULN) ? bn_r : bd_r;
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // shared subtract/compare unit
  assign x_ge_y   = (x_r >= y_r);
  assign rem_sh   = {rem_r[PW-2:0], quo_r[PW-1]};
  assign sub_a    = (state_r == S_GCD) ? (x_ge_y ? x_r : y_r) : rem_sh;
  assign sub_b    = (state_r == S_GCD) ? (x_ge_y ? y_r : x_r) : g_r;
  assign sub_d    = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow   = sub_d[PW];
  assign quo_step = {quo_r[PW-2:0], ~borrow};

  always_comb begin
    state_nxt     = state_r;
    an_nxt        = an_r;
    bn_nxt        = bn_r;
    ad_nxt        = ad_r;
    bd_nxt        = bd_r;
    num_neg_nxt   = num_neg_r;
    den_neg_nxt   = den_neg_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    g_nxt         = g_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_num_nxt   = out_num_r;
    out_den_nxt   = out_den_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          an_nxt      = mag_of(in_a_numerator[OW-1:0]);
          ad_nxt      = mag_of(in_a_denominator[OW-1:0]);
          bn_nxt      = mag_of(in_b_numerator[OW-1:0]);
          bd_nxt      = mag_of(in_b_denominator[OW-1:0]);
          num_neg_nxt = in_a_numerator[OW-1] ^ in_b_numerator[OW-1];
          den_neg_nxt = in_a_denominator[OW-1] ^ in_b_denominator[OW-1];
          state_nxt   = S_MULN;
        end
      end
      S_MULN: begin
        num_nxt   = mul_p;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        den_nxt = mul_p;
        x_nxt   = num_r;
        y_nxt   = mul_p;
        k_nxt   = '0;
        if (num_r == '0 || mul_p == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (x_r == '0 || y_r == '0) begin
          g_nxt     = (x_r == '0) ? (y_r << k_r) : (x_r << k_r);
          rem_nxt   = '0;
          quo_nxt   = num_r;
          cnt_nxt   = '0;
          state_nxt = S_DIVN;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + K_W'(1);
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_ge_y) begin
          x_nxt = sub_d[PW-1:0];
        end else begin
          y_nxt = sub_d[PW-1:0];
        end
      end
      S_DIVN, S_DIVD: begin
        rem_nxt = borrow ? rem_sh : sub_d[PW-1:0];
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          cnt_nxt = '0;
          if (state_r == S_DIVN) begin
            num_nxt   = quo_step;
            rem_nxt   = '0;
            quo_nxt   = den_r;
            state_nxt = S_DIVD;
          end else begin
            den_nxt   = quo_step;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_num_nxt   = to_bits(num_neg_r, num_r);
          out_den_nxt   = to_bits(den_neg_r, den_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    an_r      <= an_nxt;
    bn_r      <= bn_nxt;
    ad_r      <= ad_nxt;
    bd_r      <= bd_nxt;
    num_neg_r <= num_neg_nxt;
    den_neg_r <= den_neg_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    g_r       <= g_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    k_r       <= k_nxt;
    cnt_r     <= cnt_nxt;
    out_num_r <= out_num_nxt;
    out_den_r <= out_den_nxt;
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_MULN))
    else $error("request accepted but multiply did not start");

  a_zero_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MULD) && (num_r == '0 || mul_p == '0) |=> (state_r == S_DONE))
    else $error("zero product did not bypass reduction");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GCD) |-> (x_r != '0 || y_r != '0))
    else $error("gcd operands both zero");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVN || state_r == S_DIVD) |-> (g_r != '0 && rem_r < g_r))
    else $error("divider remainder not below divisor");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_valid_r && out_stall |=> (state_r == S_DONE))
    else $error("result dropped while output register full");

endmodule

`default_nettype wire

FILE: dv/tb.sv
// tb: self-checking bench for rational_multiply_reduce (exact fraction product, gcd-reduced).
// Drives randomized fraction pairs through a valid/stall driver, checks every result in order.
// Depends on rmr_pkg and the rational_multiply_reduce RTL.
`timescale 1ns / 1ps

module tb;

  localparam int FIELD_W      = rmr_pkg::FIELD_W;
  localparam int RESULT_W     = rmr_pkg::RESULT_W;
  localparam int OPW          = rmr_pkg::OPERAND_WIDTH_DEF;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int HOLD_CYCLES  = 800;
  localparam int DRAIN_CYCLES = 400;
  localparam int MAX_REPORTS  = 10;
  localparam logic signed [FIELD_W-1:0] MIN_OP = 32'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] MAX_OP = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [FIELD_W-1:0] a_num;
    logic signed [FIELD_W-1:0] a_den;
    logic signed [FIELD_W-1:0] b_num;
    logic signed [FIELD_W-1:0] b_den;
  } frac_pair_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] num;
    logic signed [RESULT_W-1:0] den;
  } ratio_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [FIELD_W-1:0] in_a_numerator = '0;
  logic signed [FIELD_W-1:0] in_a_denominator = '0;
  logic signed [FIELD_W-1:0] in_b_numerator = '0;
  logic signed [FIELD_W-1:0] in_b_denominator = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [RESULT_W-1:0] out_product_numerator;
  logic signed [RESULT_W-1:0] out_product_denominator;

  frac_pair_t pending_pairs[$];
  ratio_t     expected_ratios[$];
  frac_pair_t next_pair;
  ratio_t     want;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;
  int errors = 0;
  int cycles = 0;

  rational_multiply_reduce #(.OPERAND_WIDTH(OPW)) u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_a_numerator          (in_a_numerator),
    .in_a_denominator        (in_a_denominator),
    .in_b_numerator          (in_b_numerator),
    .in_b_denominator        (in_b_denominator),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_product_numerator   (out_product_numerator),
    .out_product_denominator (out_product_denominator)
  );

  always #10 clk = ~clk;

  // sign-extend from the operand width to 64 bits
  function automatic logic signed [RESULT_W-1:0] widen(logic signed [FIELD_W-1:0] f);
    logic signed [FIELD_W-1:0] s;
    logic signed [RESULT_W-1:0] w;
    s = f <<< (FIELD_W - OPW);
    s = s >>> (FIELD_W - OPW);
    w = s;
    return w;
  endfunction

  function automatic ratio_t multiply_reduce(frac_pair_t p);
    logic signed [RESULT_W-1:0] an, ad, bn, bd;
    logic [RESULT_W-1:0] num_mag, den_mag, x, y, t;
    logic num_neg, den_neg;
    ratio_t r;
    an = widen(p.a_num);
    ad = widen(p.a_den);
    bn = widen(p.b_num);
    bd = widen(p.b_den);
    num_mag = (an < 0 ? -an : an) * (bn < 0 ? -bn : bn);
    den_mag = (ad < 0 ? -ad : ad) * (bd < 0 ? -bd : bd);
    num_neg = ((an < 0) != (bn < 0)) && (num_mag != 0);
    den_neg = ((ad < 0) != (bd < 0)) && (den_mag != 0);
    if (num_mag != 0 && den_mag != 0) begin
      x = num_mag;
      y = den_mag;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      num_mag = num_mag / x;
      den_mag = den_mag / x;
    end
    r.num = num_neg ? -num_mag : num_mag;
    r.den = den_neg ? -den_mag : den_mag;
    return r;
  endfunction

  function automatic frac_pair_t fp(logic signed [FIELD_W-1:0] an, logic signed [FIELD_W-1:0] ad,
                                    logic signed [FIELD_W-1:0] bn, logic signed [FIELD_W-1:0] bd);
    frac_pair_t p;
    p.a_num = an;
    p.a_den = ad;
    p.b_num = bn;
    p.b_den = bd;
    return p;
  endfunction

  function automatic logic signed [FIELD_W-1:0] random_operand();
    logic signed [FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom();
      4, 5, 6: v = int'($urandom_range(0, 200)) - 100;
      7: begin
        case ($urandom_range(0, 4))
          0: v = MIN_OP;
          1: v = MAX_OP;
          2: v = -1;
          3: v = 0;
          default: v = 1;
        endcase
      end
      default: begin
        v = 32'sd1 <<< $urandom_range(0, 30);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [FIELD_W-1:0] shared_multiple(int common);
    return common * (int'($urandom_range(0, 92680)) - 46340);
  endfunction

  function automatic frac_pair_t random_pair();
    frac_pair_t p;
    int common;
    p = fp(random_operand(), random_operand(), random_operand(), random_operand());
    case ($urandom_range(0, 9))
      0: p.b_den = 1;
      1, 2: begin
        // common factor so the gcd is large
        common = $urandom_range(1, 46340);
        p = fp(shared_multiple(common), shared_multiple(common),
               shared_multiple(common), shared_multiple(common));
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic wait_idle();
    while (pending_pairs.size() != 0 || in_valid || expected_ratios.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count, bit hold);
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) pending_pairs.push_back(random_pair());
    if (hold) hold_reqs++;
    wait_idle();
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        expected_ratios.push_back(multiply_reduce(fp(in_a_numerator, in_a_denominator,
                                                     in_b_numerator, in_b_denominator)));
      if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_pair = pending_pairs.pop_front();
        in_valid <= 1'b1;
        in_a_numerator <= next_pair.a_num;
        in_a_denominator <= next_pair.a_den;
        in_b_numerator <= next_pair.b_num;
        in_b_denominator <= next_pair.b_den;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_ratios.size() == 0) begin
          note_error($sformatf("unexpected result %0d/%0d",
                               out_product_numerator, out_product_denominator));
        end else begin
          want = expected_ratios.pop_front();
          if (out_product_numerator !== want.num || out_product_denominator !== want.den)
            note_error($sformatf("mismatch: expected %0d/%0d, got %0d/%0d", want.num, want.den,
                                 out_product_numerator, out_product_denominator));
        end
      end
      if (hold_left != 0) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    pending_pairs.push_back(fp(1, 1, 1, 1));
    pending_pairs.push_back(fp(0, 5, 7, 3));
    pending_pairs.push_back(fp(3, 0, 4, 5));
    pending_pairs.push_back(fp(0, 0, 0, 0));
    pending_pairs.push_back(fp(0, -7, -9, 0));
    pending_pairs.push_back(fp(12, 18, -15, 0));
    pending_pairs.push_back(fp(MIN_OP, 0, 5, 3));
    pending_pairs.push_back(fp(MIN_OP, MIN_OP, MIN_OP, MIN_OP));
    pending_pairs.push_back(fp(MIN_OP, 1, MIN_OP, 1));
    pending_pairs.push_back(fp(1, MIN_OP, 1, MIN_OP));
    pending_pairs.push_back(fp(MAX_OP, MIN_OP, MAX_OP, MIN_OP));
    pending_pairs.push_back(fp(MAX_OP, MAX_OP - 1, MAX_OP - 1, MAX_OP));
    pending_pairs.push_back(fp(MAX_OP, 1, 1, MAX_OP));
    pending_pairs.push_back(fp(MAX_OP, MAX_OP, MAX_OP, MAX_OP));
    pending_pairs.push_back(fp(-1, -1, -1, -1));
    pending_pairs.push_back(fp(2, -4, 3, 1));
    pending_pairs.push_back(fp(-6, -4, 5, -10));
    pending_pairs.push_back(fp(7, 3, 6, 1));
    pending_pairs.push_back(fp(-7, 3, 6, 1));
    pending_pairs.push_back(fp(2147483629, 2147483587, 2147483563, 2147483549));
    pending_pairs.push_back(fp(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555));
    pending_pairs.push_back(fp(1 <<< 30, 1 <<< 15, -(1 <<< 29), 1 <<< 16));
    run_phase(0, 0, 475, 1'b1);
    run_phase(57, 0, 480, 1'b0);
    run_phase(0, 57, 480, 1'b0);
    run_phase(8, 8, 490, 1'b1);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
